>>> rtl/core/pmks_pkg.sv
// ============================================================================
// pmks_pkg
// Shared types and constants for the point-mass kinematic step block.
// ============================================================================
package pmks_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned CFG_W  = 31;
    localparam int unsigned DT_W   = 21;
    localparam int unsigned OP_W   = 3;

    localparam logic [OP_W-1:0] OP_GRAVITY = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD     = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd2;
    localparam logic [OP_W-1:0] OP_STEP    = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd4;

    localparam logic [1:0] REG_GRAVITY = 2'd0;
    localparam logic [1:0] REG_MASS    = 2'd1;
    localparam logic [1:0] REG_WIDTH   = 2'd2;

    localparam logic [CFG_W-1:0] GRAVITY_RST = 31'd642253;
    localparam logic [CFG_W-1:0] MASS_RST    = 31'd65536;
    localparam logic [CFG_W-1:0] WIDTH_RST   = 31'd6553600;

    localparam logic signed [WORD_W-1:0] HALF_Q = 32'sd32768;

    typedef logic signed [WORD_W-1:0] t_word;

    // saturate a 66-bit signed value to 32 bits
    function automatic t_word sat32(input logic signed [65:0] v);
        t_word res;
        if (v > 66'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

>>> rtl/core/pmks_div.sv
// ============================================================================
// pmks_div
// Restoring divider: signed 48-bit dividend by unsigned 31-bit divisor,
// one quotient bit per cycle, truncated toward zero.
// ============================================================================
module pmks_div
    import pmks_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [WORD_W-1:0] i_num,
    input  logic [CFG_W-1:0]         i_den,
    output logic                     o_done,
    output logic signed [WORD_W-1:0] o_quot
);

    localparam int unsigned NW = 48;

    logic [NW-1:0] r_q;
    logic [CFG_W:0] r_rem;
    logic [5:0]    r_cnt;
    logic          r_busy;
    logic          r_neg;
    logic [CFG_W-1:0] r_den;

    logic [CFG_W+1:0] w_trial;
    logic [CFG_W:0]   w_shift;
    logic [WORD_W-1:0] w_mag;
    logic signed [65:0] w_sq;

    // unsigned magnitude; -2^31 gives 0x80000000, which is still exact
    assign w_mag   = i_num[WORD_W-1] ? (32'd0 - i_num) : i_num;
    assign w_shift = {r_rem[CFG_W-1:0], r_q[NW-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_rem  <= '0;
                r_q    <= {w_mag, 16'd0};
                r_neg  <= i_num[WORD_W-1];
                r_den  <= i_den;
            end else if (r_busy) begin
                if (!w_trial[CFG_W+1]) begin
                    r_rem <= w_trial[CFG_W:0];
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift;
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'(NW - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // quotient magnitude is up to 48 bits; sign applied, then saturated
    logic signed [65:0] w_mq;
    assign w_mq = $signed({18'd0, r_q});
    assign w_sq = r_neg ? -w_mq : w_mq;
    assign o_quot = sat32(w_sq);

endmodule

>>> rtl/core/point_mass_kinematic_step.sv
// ============================================================================
// point_mass_kinematic_step
// Three-axis Q16.16 point-mass integrator with a shared multiplier/divider.
// ============================================================================
// Usage:
//   Input channel i_valid/o_ready carries one operation and its operands.
//   Output channel o_valid/i_ready returns the full state after each
//   operation. Configuration is a plain write port (i_cfg_we, i_cfg_idx,
//   i_cfg_data): 0 gravity, 1 mass, 2 arena width.
//   Gravity, clear and unused codes go from idle straight to the output
//   state; a force runs one 48-step divide per axis (mass nonzero); a
//   step passes each axis through S_M1, S_M2 and S_M3 on one shared
//   37 x 33 bit signed multiplier. One item is in work at a time; o_ready
//   is low until the result has been transferred.
//   Reset clears position, velocity, acceleration and restores the
//   register reset values. When the receiver stalls the result register
//   holds and no new item is taken.
// ============================================================================
module point_mass_kinematic_step
    import pmks_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_idx,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [OP_W-1:0]          i_operation,
    input  logic signed [WORD_W-1:0] i_force_x,
    input  logic signed [WORD_W-1:0] i_force_y,
    input  logic signed [WORD_W-1:0] i_force_z,
    input  logic [DT_W-1:0]          i_time_step,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [WORD_W-1:0] o_pos_x,
    output logic signed [WORD_W-1:0] o_pos_y,
    output logic signed [WORD_W-1:0] o_pos_z,
    output logic signed [WORD_W-1:0] o_vel_x,
    output logic signed [WORD_W-1:0] o_vel_y,
    output logic signed [WORD_W-1:0] o_vel_z,
    output logic signed [WORD_W-1:0] o_acc_x,
    output logic signed [WORD_W-1:0] o_acc_y,
    output logic signed [WORD_W-1:0] o_acc_z
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_DIV   = 7'b0000010,
        S_DWAIT = 7'b0000100,
        S_M1    = 7'b0001000,
        S_M2    = 7'b0010000,
        S_M3    = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;
    logic [CFG_W-1:0] r_grav, r_mass, r_width;
    t_word r_pos [3];
    t_word r_vel [3];
    t_word r_acc [3];
    t_word r_f [3];
    logic [OP_W-1:0] r_op;
    logic [DT_W-1:0] r_dt;
    logic [1:0] r_ax;
    logic signed [65:0] r_m;      // position accumulator
    logic signed [65:0] r_adt;

    // shared multiplier; v + floor(a*dt/2^17) needs 37 bits
    logic signed [WORD_W+4:0] w_ma;
    logic signed [WORD_W:0] w_mb;
    logic signed [65:0] w_prod;
    assign w_prod = 66'(w_ma * w_mb);

    logic        w_dstart, w_ddone;
    t_word       w_quot;
    pmks_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_dstart),
        .i_num  (r_f[r_ax]),
        .i_den  (r_mass),
        .o_done (w_ddone),
        .o_quot (w_quot)
    );
    assign w_dstart = (r_state == S_DIV) && (r_mass != '0);

    logic signed [WORD_W+4:0] w_q;
    t_word w_fq;
    // q = floor(adt/2^17); a*dt fits in 53 signed bits
    assign w_q = $signed(r_adt[53:17]);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_M1: begin
                w_ma = $signed({{5{r_acc[r_ax][WORD_W-1]}}, r_acc[r_ax]});
                w_mb = $signed({12'd0, r_dt});
            end
            S_M2: begin
                w_ma = $signed({{5{r_vel[r_ax][WORD_W-1]}}, r_vel[r_ax]}) + w_q;
                w_mb = $signed({12'd0, r_dt});
            end
            S_M3: begin
                w_ma = $signed({20'd0, r_adt[16:0]});
                w_mb = $signed({12'd0, r_dt});
            end
            default: ;
        endcase
    end

    always_comb begin
        if (r_mass == '0) begin
            if (r_f[r_ax] > 0) w_fq = 32'sh7fffffff;
            else if (r_f[r_ax] < 0) w_fq = 32'sh80000000;
            else w_fq = '0;
        end else begin
            w_fq = w_quot;
        end
    end

    t_word w_upper;
    assign w_upper = $signed({1'b0, r_width}) - HALF_Q;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_pos_x = r_pos[0];
    assign o_pos_y = r_pos[1];
    assign o_pos_z = r_pos[2];
    assign o_vel_x = r_vel[0];
    assign o_vel_y = r_vel[1];
    assign o_vel_z = r_vel[2];
    assign o_acc_x = r_acc[0];
    assign o_acc_y = r_acc[1];
    assign o_acc_z = r_acc[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_grav  <= GRAVITY_RST;
            r_mass  <= MASS_RST;
            r_width <= WIDTH_RST;
            for (int k = 0; k < 3; k++) begin
                r_pos[k] <= '0;
                r_vel[k] <= '0;
                r_acc[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_GRAVITY: r_grav  <= i_cfg_data;
                    REG_MASS:    r_mass  <= i_cfg_data;
                    REG_WIDTH:   r_width <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op   <= i_operation;
                        r_dt   <= i_time_step;
                        r_f[0] <= i_force_x;
                        r_f[1] <= i_force_y;
                        r_f[2] <= i_force_z;
                        r_ax   <= 2'd0;
                        r_state <= S_OUT;
                        case (i_operation)
                            OP_GRAVITY: r_acc[1] <= sat32(66'(r_acc[1])
                                                   - $signed({35'd0, r_grav}));
                            OP_ADD, OP_REMOVE: r_state <= S_DIV;
                            OP_CLEAR: begin
                                for (int k = 0; k < 3; k++) begin
                                    r_vel[k] <= '0;
                                    r_acc[k] <= '0;
                                end
                            end
                            OP_STEP: begin
                                // wall clamp: lower x, then upper x, then lower y
                                if (r_pos[0] > w_upper || (r_pos[0] < HALF_Q)) begin
                                    r_pos[0] <= (r_pos[0] > w_upper) ? w_upper
                                              : ((HALF_Q > w_upper) ? w_upper : HALF_Q);
                                    r_vel[0] <= '0;
                                    r_acc[0] <= '0;
                                end
                                if (r_pos[1] < HALF_Q) begin
                                    r_pos[1] <= HALF_Q;
                                    r_vel[1] <= '0;
                                    r_acc[1] <= '0;
                                end
                                r_state <= S_M1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    r_state <= (r_mass == '0) ? S_DWAIT : S_DWAIT;
                end
                S_DWAIT: begin
                    if (w_ddone || r_mass == '0) begin
                        if (r_op == OP_ADD)
                            r_acc[r_ax] <= sat32(66'(r_acc[r_ax]) + 66'(w_fq));
                        else
                            r_acc[r_ax] <= sat32(66'(r_acc[r_ax]) - 66'(w_fq));
                        if (r_ax == 2'd2) begin
                            r_state <= S_OUT;
                        end else begin
                            r_ax <= r_ax + 2'd1;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_M1: begin
                    r_adt   <= w_prod;
                    r_state <= S_M2;
                end
                S_M2: begin
                    // s*2^16 + (v + q)*dt
                    r_m <= $signed({{18{r_pos[r_ax][WORD_W-1]}}, r_pos[r_ax], 16'd0})
                           + w_prod;
                    r_vel[r_ax] <= sat32(($signed({{18{r_vel[r_ax][WORD_W-1]}},
                                   r_vel[r_ax], 16'd0}) + r_adt) >>> 16);
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_pos[r_ax] <= sat32((r_m + (w_prod >>> 17)) >>> 16);
                    if (r_ax == 2'd2) begin
                        r_state <= S_OUT;
                    end else begin
                        r_ax <= r_ax + 2'd1;
                        r_state <= S_M1;
                    end
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
